@@ sv/mrsp_pkg.sv @@
// ============================================================================
// mrsp_pkg
// Shared types and constants of the menu record stream parser: the input and
// result item layouts, the result kind codes and the string field limits.
// ============================================================================
package mrsp_pkg;

  // Result kind codes
  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_DONE = 3'd1;
  localparam logic [2:0] KIND_END  = 3'd2;
  localparam logic [2:0] KIND_ERR  = 3'd3;
  localparam logic [2:0] KIND_OVF  = 3'd4;

  // String field codes
  localparam logic [1:0] FIELD_TEXT    = 2'd0;
  localparam logic [1:0] FIELD_COMMAND = 2'd1;
  localparam logic [1:0] FIELD_ENV_ID  = 2'd2;
  localparam logic [1:0] FIELD_PREFIX  = 2'd3;

  // Maximum kept length of each string field
  localparam logic [8:0] TEXT_MAX_LEN    = 9'd128;
  localparam logic [8:0] COMMAND_MAX_LEN = 9'd256;
  localparam logic [8:0] ENV_ID_MAX_LEN  = 9'd64;
  localparam logic [8:0] PREFIX_MAX_LEN  = 9'd64;

  // Register reset value
  localparam logic [7:0] ENTRY_LIMIT_RESET = 8'd16;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_file;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  string_field;
    logic [7:0]  char_position;
    logic [7:0]  char_value;
    logic [7:0]  record_type;
    logic [31:0] record_flags;
    logic [7:0]  record_index;
    logic        run_last;
  } out_item_t;

  // Queue entry: all results of one input item. A second result never
  // carries payload, so only its kind is kept.
  typedef struct packed {
    out_item_t  first;
    logic       has_second;
    logic [2:0] second_kind;
  } entry_t;

  // Kept length limit of a string field
  function automatic logic [8:0] field_limit(input logic [1:0] field);
    logic [8:0] lim;
    unique case (field)
      FIELD_TEXT:    lim = TEXT_MAX_LEN;
      FIELD_COMMAND: lim = COMMAND_MAX_LEN;
      FIELD_ENV_ID:  lim = ENV_ID_MAX_LEN;
      default:       lim = PREFIX_MAX_LEN;
    endcase
    return lim;
  endfunction

endpackage

@@ sv/mrsp_front.sv @@
// ============================================================================
// mrsp_front
// Front end: accepts input items while the queue has room, runs the record
// parser one byte a cycle and queues the results of each item as one entry.
// ============================================================================
module mrsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mrsp_pkg::in_item_t in_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              space_i,
  output logic              push_o,
  output mrsp_pkg::entry_t  entry_o
);
  import mrsp_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_FLAGS,
    PH_LEN,
    PH_STR,
    PH_TERM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  digit_q, digit_d;
  logic [27:0] acc_q, acc_d;
  logic [15:0] rem_q, rem_d;
  logic [8:0]  kept_q, kept_d;
  logic [1:0]  cur_q, cur_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] flags_q, flags_d;
  logic [7:0]  rec_q, rec_d;
  logic        stop_q, stop_d;
  logic        fbad_q, fbad_d;
  logic [7:0]  max_q;

  logic        accept;
  logic        bad;
  logic [3:0]  dig;
  logic        r0_v, r1_v;
  out_item_t   r0;
  logic [2:0]  r1_kind;
  logic [2:0]  end_kind;

  // Hex digit decode: bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (b >= "0" && b <= "9") begin
      v = {1'b0, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      v = {1'b0, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      v = {1'b0, 4'(b - "A" + 8'd10)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  // Parser next state and results
  always_comb begin
    logic [4:0] hv;
    hv       = hex_value(in_data_i.data_byte);
    bad      = hv[4];
    dig      = hv[3:0];
    phase_d  = phase_q;
    digit_d  = digit_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    kept_d   = kept_q;
    cur_d    = cur_q;
    type_d   = type_q;
    flags_d  = flags_q;
    rec_d    = rec_q;
    stop_d   = stop_q;
    fbad_d   = fbad_q;
    r0       = '0;
    r0_v     = 1'b0;
    r1_v     = 1'b0;
    r1_kind  = KIND_END;
    end_kind = KIND_END;

    if (accept && !stop_q) begin
      // byte first
      if (in_data_i.byte_present) begin
        unique case (phase_q)
          PH_TYPE: begin
            if (digit_q == 3'd0) begin
              if (rec_q >= max_q) begin
                r0_v           = 1'b1;
                r0.result_kind = KIND_OVF;
                stop_d         = 1'b1;
              end else begin
                fbad_d  = bad;
                acc_d   = {24'd0, dig};
                digit_d = 3'd1;
              end
            end else if (fbad_q || bad) begin
              r0_v           = 1'b1;
              r0.result_kind = KIND_ERR;
              stop_d         = 1'b1;
            end else begin
              type_d  = {acc_q[3:0], dig};
              acc_d   = '0;
              digit_d = 3'd0;
              phase_d = PH_FLAGS;
            end
          end
          PH_FLAGS: begin
            if (bad) begin
              r0_v           = 1'b1;
              r0.result_kind = KIND_ERR;
              stop_d         = 1'b1;
            end else if (digit_q == 3'd7) begin
              flags_d = {acc_q, dig};
              acc_d   = '0;
              digit_d = 3'd0;
              cur_d   = FIELD_TEXT;
              phase_d = PH_LEN;
            end else begin
              acc_d   = {acc_q[23:0], dig};
              digit_d = digit_q + 3'd1;
            end
          end
          PH_LEN: begin
            if (bad) begin
              r0_v           = 1'b1;
              r0.result_kind = KIND_ERR;
              stop_d         = 1'b1;
            end else if (digit_q == 3'd3) begin
              rem_d   = {acc_q[11:0], dig};
              acc_d   = '0;
              digit_d = 3'd0;
              kept_d  = '0;
              if ({acc_q[11:0], dig} != 16'd0) begin
                phase_d = PH_STR;
              end else if (cur_q == FIELD_PREFIX) begin
                phase_d = PH_TERM;
              end else begin
                cur_d   = cur_q + 2'd1;
                phase_d = PH_LEN;
              end
            end else begin
              acc_d   = {acc_q[23:0], dig};
              digit_d = digit_q + 3'd1;
            end
          end
          PH_STR: begin
            if (kept_q < field_limit(cur_q)) begin
              r0_v             = 1'b1;
              r0.result_kind   = KIND_CHAR;
              r0.string_field  = cur_q;
              r0.char_position = kept_q[7:0];
              r0.char_value    = in_data_i.data_byte;
              kept_d           = kept_q + 9'd1;
            end
            rem_d = rem_q - 16'd1;
            if (rem_q == 16'd1) begin
              if (cur_q == FIELD_PREFIX) begin
                phase_d = PH_TERM;
              end else begin
                cur_d   = cur_q + 2'd1;
                phase_d = PH_LEN;
              end
            end
          end
          default: begin
            // terminator: record summary, then overflow check
            r0_v            = 1'b1;
            r0.result_kind  = KIND_DONE;
            r0.record_type  = type_q;
            r0.record_flags = flags_q;
            r0.record_index = rec_q;
            rec_d           = rec_q + 8'd1;
            phase_d         = PH_TYPE;
            digit_d         = 3'd0;
            acc_d           = '0;
            fbad_d          = 1'b0;
            if (({1'b0, rec_q} + 9'd1) >= {1'b0, max_q}) begin
              r1_v    = 1'b1;
              r1_kind = KIND_OVF;
              stop_d  = 1'b1;
            end
          end
        endcase
      end

      // then end of file
      if (!stop_d && in_data_i.end_of_file) begin
        if (phase_d == PH_TYPE && digit_d <= 3'd1) begin
          end_kind = (digit_d == 3'd0 && rec_d >= max_q) ? KIND_OVF : KIND_END;
        end else begin
          end_kind = KIND_ERR;
        end
        stop_d = 1'b1;
        if (r0_v) begin
          r1_v    = 1'b1;
          r1_kind = end_kind;
        end else begin
          r0_v           = 1'b1;
          r0.result_kind = end_kind;
        end
      end
    end
  end

  // Queue entry
  always_comb begin
    entry_o                = '0;
    entry_o.first          = r0;
    entry_o.first.run_last = !r1_v;
    entry_o.has_second     = r1_v;
    entry_o.second_kind    = r1_kind;
  end
  assign push_o = r0_v;

  // Parser state and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      digit_q <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      kept_q  <= '0;
      cur_q   <= '0;
      type_q  <= '0;
      flags_q <= '0;
      rec_q   <= '0;
      stop_q  <= 1'b0;
      fbad_q  <= 1'b0;
      max_q   <= ENTRY_LIMIT_RESET;
    end else begin
      phase_q <= phase_d;
      digit_q <= digit_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      kept_q  <= kept_d;
      cur_q   <= cur_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      rec_q   <= rec_d;
      stop_q  <= stop_d;
      fbad_q  <= fbad_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ sv/mrsp_queue.sv @@
// ============================================================================
// mrsp_queue
// Small register FIFO of result entries between the parser front end and
// the result back end.
// ============================================================================
module mrsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mrsp_pkg::entry_t entry_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             avail_o,
  output mrsp_pkg::entry_t head_o
);
  import mrsp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign space_o = cnt_q != CW'(DEPTH);
  assign avail_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && avail_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ sv/mrsp_back.sv @@
// ============================================================================
// mrsp_back
// Back end: takes queue entries and issues their one or two result items
// through an output register.
// ============================================================================
module mrsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  mrsp_pkg::entry_t   head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrsp_pkg::out_item_t out_data_o
);
  import mrsp_pkg::*;

  logic       valid_q;
  out_item_t  data_q;
  logic       pend_q;
  logic [2:0] pend_kind_q;
  logic       slot_free;
  out_item_t  second;

  assign slot_free   = !valid_q || out_ready_i;
  assign pop_o       = slot_free && !pend_q && avail_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Second result of an entry: kind only, always last of its item
  always_comb begin
    second             = '0;
    second.result_kind = pend_kind_q;
    second.run_last    = 1'b1;
  end

  // Output register: a pending second result goes before the next entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_kind_q <= KIND_END;
      data_q      <= '0;
    end else if (slot_free) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        data_q  <= second;
        pend_q  <= 1'b0;
      end else if (avail_i) begin
        valid_q     <= 1'b1;
        data_q      <= head_i.first;
        pend_q      <= head_i.has_second;
        pend_kind_q <= head_i.second_kind;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ sv/menu_record_stream_parser_core.sv @@
// ============================================================================
// menu_record_stream_parser_core
// Boot-menu record stream parser: bytes in, kept string characters, record
// summaries and end, error and overflow results out.
// ============================================================================
// The block accepts one input item per clock cycle whenever its internal
// result queue (QDEPTH entries) has room. The parser front end handles each
// item in the cycle that it is accepted and queues all of its results
// together; the back end then issues one result item per cycle through an
// output register while out_ready_i is high. An item causes zero, one or two
// results; with a ready output port the sustained rate is one item per cycle
// for items with at most one result, while an item that ends with two (record
// done plus overflow, or a byte result plus the end result) holds the back
// end until both are issued. There is no clearing pass after reset. The user
// must write the entry limit register through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this.
module menu_record_stream_parser_core #(
  parameter int QDEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrsp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mrsp_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import mrsp_pkg::*;

  logic   space, push, pop, avail;
  entry_t entry, head;

  // Parser front end
  mrsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .space_i     (space),
    .push_o      (push),
    .entry_o     (entry)
  );

  // Result queue
  mrsp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .space_o (space),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  // Result back end
  mrsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
